@@ rtl/core/crsf_pkg.sv @@
// Shared types and constants for the column range select filter.
package crsf_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_WIDTH = 3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LOW_VALUE      = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_HIGH_VALUE     = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_HIGH_GIVEN     = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LOW_INCLUSIVE  = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_HIGH_INCLUSIVE = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ANTI_MODE      = 3'd5;

  // Reset values of the flag registers.
  localparam logic HIGH_GIVEN_RESET     = 1'b1;
  localparam logic LOW_INCLUSIVE_RESET  = 1'b0;
  localparam logic HIGH_INCLUSIVE_RESET = 1'b0;
  localparam logic ANTI_MODE_RESET      = 1'b0;

  // Normalized form of the predicate after all special cases are folded in.
  typedef struct packed {
    logic empty;   // nothing qualifies
    logic equi;    // point select: value key must equal the low key
    logic anti;    // complement of the range
    logic lval;    // low bound is active
    logic hval;    // high bound is active
    logic li;      // low bound inclusive
    logic hi;      // high bound inclusive
  } crsf_flags_t;

endpackage

@@ rtl/core/crsf_decode.sv @@
// Folds the range predicate registers into a normalized bound pair and flags.
module crsf_decode
  import crsf_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic [DATA_WIDTH-1:0] low_value,
  input  logic [DATA_WIDTH-1:0] high_value,
  input  logic                  high_given,
  input  logic                  low_inclusive,
  input  logic                  high_inclusive,
  input  logic                  anti_mode,
  output crsf_flags_t           flags,
  output logic [DATA_WIDTH-1:0] low_key,
  output logic [DATA_WIDTH-1:0] high_key
);

  // Flipping the sign bit gives an unsigned key with the same order; nil maps to zero.
  localparam logic [DATA_WIDTH-1:0] SIGN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  always_comb begin
    logic [DATA_WIDTH-1:0] tl;
    logic [DATA_WIDTH-1:0] th;
    logic [DATA_WIDTH-1:0] tv;
    logic lnil;
    logic lval;
    logic hval;
    logic equi;
    logic anti;
    logic li;
    logic hi;
    logic tb;
    logic empty;

    tl    = low_value ^ SIGN;
    th    = high_value ^ SIGN;
    tv    = '0;
    tb    = 1'b0;
    lnil  = (tl == '0);
    lval  = !lnil || !high_given;
    equi  = !high_given || (lval && (tl == th));
    anti  = anti_mode;
    li    = low_inclusive;
    hi    = high_inclusive;
    empty = 1'b0;

    if (equi) begin
      if (!high_given) begin
        hi = li;
      end
      th   = tl;
      hval = 1'b1;
    end else begin
      hval = (th != '0);
    end

    if (anti) begin
      if (lval != hval) begin
        // One open side: the complement is a plain range over the other side.
        tv   = tl;
        tb   = li;
        li   = !hi;
        hi   = !tb;
        tl   = th;
        th   = tv;
        tb   = lval;
        lval = hval;
        hval = tb;
        anti = 1'b0;
      end else if (!lval && !hval) begin
        empty = 1'b1;
      end else if (equi && lnil) begin
        // Complement of the nil point select is every non-nil value.
        equi = 1'b0;
        anti = 1'b0;
        lval = 1'b0;
        hval = 1'b0;
      end else begin
        equi = 1'b0;
      end
    end

    if (hval && ((equi && !(li && hi)) || (tl > th))) begin
      empty = 1'b1;
    end

    flags.empty = empty;
    flags.equi  = equi;
    flags.anti  = anti;
    flags.lval  = lval;
    flags.hval  = hval;
    flags.li    = li;
    flags.hi    = hi;
    low_key     = tl;
    high_key    = th;
  end

endmodule

@@ rtl/core/column_range_select_filter.sv @@
// Top level of the column range select filter: config registers and the two-stage datapath.
// Path: input register, then result register. Throughput: one item per cycle while the
// output is taken; the input register and the result register each hold one item, so the
// block takes one more item while a finished result waits to be taken.
// Reset: rst is synchronous and active high; it empties both stages, holds s_tready low,
// and returns the predicate registers to nil bounds, high given, exclusive, not anti.
module column_range_select_filter
  import crsf_pkg::*;
#(
  parameter int unsigned DATA_WIDTH   = 32,
  parameter int unsigned ROW_ID_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,

  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [DATA_WIDTH-1:0]      cfg_data,

  input  logic                                                 s_tvalid,
  output logic                                                 s_tready,
  // Fields from bit 0: row_id, value, zero fill.
  input  logic [((ROW_ID_WIDTH + DATA_WIDTH + 7) / 8) * 8-1:0] s_tdata,
  input  logic                                                 s_tlast,

  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  // Fields from bit 0: match_row_id, zero fill.
  output logic [((ROW_ID_WIDTH + 7) / 8) * 8-1:0]   m_tdata,
  // Fields from bit 0: selected.
  output logic                                      m_tuser,
  output logic                                      m_tlast
);

  localparam int unsigned OUT_W = ((ROW_ID_WIDTH + 7) / 8) * 8;
  localparam logic [DATA_WIDTH-1:0] SIGN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // Predicate registers.
  logic [DATA_WIDTH-1:0] low_value;
  logic [DATA_WIDTH-1:0] high_value;
  logic                  high_given;
  logic                  low_inclusive;
  logic                  high_inclusive;
  logic                  anti_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_value      <= SIGN;
      high_value     <= SIGN;
      high_given     <= HIGH_GIVEN_RESET;
      low_inclusive  <= LOW_INCLUSIVE_RESET;
      high_inclusive <= HIGH_INCLUSIVE_RESET;
      anti_mode      <= ANTI_MODE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOW_VALUE:      low_value      <= cfg_data;
        REG_HIGH_VALUE:     high_value     <= cfg_data;
        REG_HIGH_GIVEN:     high_given     <= cfg_data[0];
        REG_LOW_INCLUSIVE:  low_inclusive  <= cfg_data[0];
        REG_HIGH_INCLUSIVE: high_inclusive <= cfg_data[0];
        REG_ANTI_MODE:      anti_mode      <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  crsf_flags_t           flags;
  logic [DATA_WIDTH-1:0] low_key;
  logic [DATA_WIDTH-1:0] high_key;

  crsf_decode #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_decode (
    .low_value     (low_value),
    .high_value    (high_value),
    .high_given    (high_given),
    .low_inclusive (low_inclusive),
    .high_inclusive(high_inclusive),
    .anti_mode     (anti_mode),
    .flags         (flags),
    .low_key       (low_key),
    .high_key      (high_key)
  );

  // Input stage.
  logic                    in_valid;
  logic [ROW_ID_WIDTH-1:0] in_row_id;
  logic [DATA_WIDTH-1:0]   in_value;
  logic                    in_last;
  logic                    advance;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !rst && (!in_valid || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_row_id <= s_tdata[ROW_ID_WIDTH-1:0];
      in_value  <= s_tdata[ROW_ID_WIDTH +: DATA_WIDTH];
      in_last   <= s_tlast;
    end
  end

  // Range test against the normalized bounds.
  logic [DATA_WIDTH-1:0] vkey;
  logic                  low_ok;
  logic                  high_ok;
  logic                  anti_hit;
  logic                  selected_next;

  assign vkey     = in_value ^ SIGN;
  assign low_ok   = !flags.lval || (low_key < vkey) || (flags.li && (low_key == vkey));
  assign high_ok  = !flags.hval || (high_key > vkey) || (flags.hi && (high_key == vkey));
  assign anti_hit = (flags.lval && ((low_key > vkey) || (!flags.li && (low_key == vkey)))) ||
                    (flags.hval && ((high_key < vkey) || (!flags.hi && (high_key == vkey))));

  always_comb begin
    if (flags.empty) begin
      selected_next = 1'b0;
    end else if (flags.equi) begin
      selected_next = (vkey == low_key);
    end else if (vkey == '0) begin
      selected_next = 1'b0;
    end else if (flags.anti) begin
      selected_next = anti_hit;
    end else begin
      selected_next = low_ok && high_ok;
    end
  end

  // Result stage.
  logic [ROW_ID_WIDTH-1:0] out_row_id;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_row_id <= in_row_id;
      m_tuser    <= selected_next;
      m_tlast    <= in_last;
    end
  end

  assign m_tdata = OUT_W'(out_row_id);

  // A transfer in always lands in the input stage.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> in_valid)
    else $error("accepted item missing from input stage");

  // An item in the input stage moves to the result stage when that stage frees up.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && advance) |=> m_tvalid)
    else $error("item lost between input and result stages");

  // With nothing behind it, a taken result leaves the output empty.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !in_valid) |=> !m_tvalid)
    else $error("result repeated on the output");

  // After folding, a complement is never a point select.
  assert property (@(posedge clk) disable iff (rst)
    !(flags.anti && flags.equi))
    else $error("decoded predicate is both anti and point select");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the column range select filter: filter settings, rows and verdicts.
`timescale 1ns / 1ps

module tb_top
  import crsf_pkg::*;
();

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned ROW_W      = 32;
  localparam int unsigned S_DATA_W   = ((ROW_W + DATA_W + 7) / 8) * 8;
  localparam int unsigned M_DATA_W   = ((ROW_W + 7) / 8) * 8;
  localparam int          CORNER_CNT = 20;
  localparam int          PHASE_CNT  = 40;
  localparam int          STALL_LIMIT = 2000;

  localparam logic [DATA_W-1:0] NIL_VALUE = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] MAX_VALUE = {1'b0, {(DATA_W-1){1'b1}}};

  // Indexes past the last register; writes to them must change nothing.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_B = 3'd7;

  typedef struct packed {
    logic [DATA_W-1:0] lo_bound;
    logic [DATA_W-1:0] hi_bound;
    logic              hi_given;
    logic              lo_incl;
    logic              hi_incl;
    logic              anti;
  } filter_cfg_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row_id;
    logic [DATA_W-1:0] value;
    logic              last;
  } column_row_t;

  typedef struct packed {
    logic [ROW_W-1:0] row_id;
    logic             selected;
    logic             end_of_column;
  } verdict_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_we = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [DATA_W-1:0]          cfg_data = '0;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [S_DATA_W-1:0]        s_tdata = '0;   // row_id, value
  logic                       s_tlast = 1'b0;
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [M_DATA_W-1:0]        m_tdata;        // match_row_id
  logic                       m_tuser;        // selected
  logic                       m_tlast;

  filter_cfg_t filter;
  filter_cfg_t corner_filters [0:CORNER_CNT-1];
  column_row_t pending_rows[$];
  verdict_t    expected_verdicts[$];

  int send_idle_pct = 35;
  int recv_idle_pct = 61;
  int rows_sent = 0;
  int verdicts_seen = 0;
  int rows_selected = 0;
  int mismatches = 0;
  int filter_settings = 1;
  int stall_cycles = 0;

  column_range_select_filter #(
    .DATA_WIDTH  (DATA_W),
    .ROW_ID_WIDTH(ROW_W)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // Range predicate on order keys: flipping the sign bit makes unsigned order match
  // signed order and sends nil to key zero.
  function automatic logic row_qualifies(logic [DATA_W-1:0] raw);
    logic [DATA_W-1:0] key, lo_key, hi_key, swap_key;
    logic lo_inc, hi_inc, lo_nil, lo_on, hi_on, point, compl, swap_bit;
    key    = raw ^ NIL_VALUE;
    lo_key = filter.lo_bound ^ NIL_VALUE;
    hi_key = filter.hi_bound ^ NIL_VALUE;
    lo_inc = filter.lo_incl;
    hi_inc = filter.hi_incl;
    lo_nil = (lo_key == '0);
    lo_on  = !lo_nil || !filter.hi_given;
    point  = !filter.hi_given || (lo_on && lo_key == hi_key);
    compl  = filter.anti;
    if (point) begin
      if (!filter.hi_given) hi_inc = lo_inc;
      hi_key = lo_key;
      hi_on  = 1'b1;
    end else begin
      hi_on = (hi_key != '0);
    end
    if (compl) begin
      if (lo_on != hi_on) begin
        // The complement of a one-sided range is the other side with the bound flipped.
        swap_key = lo_key;
        swap_bit = lo_inc;
        lo_inc   = !hi_inc;
        hi_inc   = !swap_bit;
        lo_key   = hi_key;
        hi_key   = swap_key;
        swap_bit = lo_on;
        lo_on    = hi_on;
        hi_on    = swap_bit;
        compl    = 1'b0;
      end else if (!lo_on && !hi_on) begin
        return 1'b0;
      end else if (point && lo_nil) begin
        point = 1'b0;
        compl = 1'b0;
        lo_on = 1'b0;
        hi_on = 1'b0;
      end else begin
        point = 1'b0;
      end
    end
    if (hi_on && ((point && !(lo_inc && hi_inc)) || lo_key > hi_key)) return 1'b0;
    if (point) return key == lo_key;
    if (key == '0) return 1'b0;
    if (compl)
      return (lo_on && (lo_key > key || (!lo_inc && lo_key == key))) ||
             (hi_on && (hi_key < key || (!hi_inc && hi_key == key)));
    return (!lo_on || lo_key < key || (lo_inc && lo_key == key)) &&
           (!hi_on || hi_key > key || (hi_inc && hi_key == key));
  endfunction

  function automatic filter_cfg_t make_filter(logic [DATA_W-1:0] lo, logic [DATA_W-1:0] hi,
                                              logic given, logic lo_inc, logic hi_inc,
                                              logic compl);
    filter_cfg_t f;
    f.lo_bound = lo;
    f.hi_bound = hi;
    f.hi_given = given;
    f.lo_incl  = lo_inc;
    f.hi_incl  = hi_inc;
    f.anti     = compl;
    return f;
  endfunction

  function automatic logic [DATA_W-1:0] boundary_value();
    case ($urandom_range(6))
      0: return NIL_VALUE;
      1: return MAX_VALUE;
      2: return NIL_VALUE + 1;
      3: return '0;
      4: return $urandom_range(200) - 100;
      default: return $urandom;
    endcase
  endfunction

  function automatic filter_cfg_t random_filter();
    filter_cfg_t f;
    f.lo_bound = boundary_value();
    case ($urandom_range(3))
      0: f.hi_bound = boundary_value();
      1: f.hi_bound = f.lo_bound + $urandom_range(40);
      2: f.hi_bound = f.lo_bound;
      default: f.hi_bound = NIL_VALUE;
    endcase
    f.hi_given = ($urandom_range(4) != 0);
    f.lo_incl  = 1'($urandom_range(1));
    f.hi_incl  = 1'($urandom_range(1));
    f.anti     = 1'($urandom_range(1));
    return f;
  endfunction

  // Values cluster around the current bounds and the ends of the range.
  function automatic column_row_t random_row();
    column_row_t r;
    r.row_id = $urandom;
    r.last   = ($urandom_range(15) == 0);
    case ($urandom_range(13))
      0: r.value = filter.lo_bound;
      1: r.value = filter.lo_bound - 1;
      2: r.value = filter.lo_bound + 1;
      3: r.value = filter.hi_bound;
      4: r.value = filter.hi_bound - 1;
      5: r.value = filter.hi_bound + 1;
      6: r.value = NIL_VALUE;
      7: r.value = NIL_VALUE + 1;
      8: r.value = MAX_VALUE;
      9: r.value = '0;
      10: r.value = '1;
      default: r.value = $urandom;
    endcase
    return r;
  endfunction

  task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_LOW_VALUE:      filter.lo_bound = data;
      REG_HIGH_VALUE:     filter.hi_bound = data;
      REG_HIGH_GIVEN:     filter.hi_given = data[0];
      REG_LOW_INCLUSIVE:  filter.lo_incl  = data[0];
      REG_HIGH_INCLUSIVE: filter.hi_incl  = data[0];
      REG_ANTI_MODE:      filter.anti     = data[0];
      default: ;
    endcase
  endtask

  // Flag registers get random upper bits, which the block must ignore.
  task automatic apply_filter(filter_cfg_t f);
    logic [DATA_W-1:0] junk;
    write_reg(REG_LOW_VALUE, f.lo_bound);
    write_reg(REG_HIGH_VALUE, f.hi_bound);
    junk = $urandom;
    junk[0] = f.hi_given;
    write_reg(REG_HIGH_GIVEN, junk);
    junk = $urandom;
    junk[0] = f.lo_incl;
    write_reg(REG_LOW_INCLUSIVE, junk);
    junk = $urandom;
    junk[0] = f.hi_incl;
    write_reg(REG_HIGH_INCLUSIVE, junk);
    junk = $urandom;
    junk[0] = f.anti;
    write_reg(REG_ANTI_MODE, junk);
    if ($urandom_range(1) == 0) write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    filter_settings++;
  endtask

  // Holds off new rows until every verdict is back.
  task automatic drain();
    while (pending_rows.size() != 0 || s_tvalid || expected_verdicts.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  always @(posedge clk) begin : row_driver
    logic busy;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      busy = s_tvalid;
      if (s_tvalid && s_tready) begin
        expected_verdicts.push_back({pending_rows[0].row_id,
                                     row_qualifies(pending_rows[0].value),
                                     pending_rows[0].last});
        pending_rows.pop_front();
        rows_sent++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (pending_rows.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= {pending_rows[0].value, pending_rows[0].row_id};
          s_tlast  <= pending_rows[0].last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : verdict_monitor
    verdict_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.row_id        = m_tdata[ROW_W-1:0];
        got.selected      = m_tuser;
        got.end_of_column = m_tlast;
        verdicts_seen++;
        if (got.selected === 1'b1) rows_selected++;
        if (expected_verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] verdict with no row pending: row_id %h selected %b end %b",
                     $realtime, got.row_id, got.selected, got.end_of_column);
        end else begin
          want = expected_verdicts.pop_front();
          if (got.row_id !== want.row_id || got.selected !== want.selected ||
              got.end_of_column !== want.end_of_column) begin
            mismatches++;
            if (mismatches <= 10)
              $display("[%0t] verdict mismatch: row_id %h/%h selected %b/%b end %b/%b",
                       $realtime, want.row_id, got.row_id, want.selected, got.selected,
                       want.end_of_column, got.end_of_column);
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("no transfer for %0d cycles", STALL_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    column_row_t row;
    filter_cfg_t next_filter;
    int          row_cnt;
    filter = make_filter(NIL_VALUE, NIL_VALUE, HIGH_GIVEN_RESET, LOW_INCLUSIVE_RESET,
                         HIGH_INCLUSIVE_RESET, ANTI_MODE_RESET);

    // point select
    corner_filters[0]  = make_filter(100, 0, 1'b0, 1'b1, 1'b0, 1'b0);
    // exclusive point, empty
    corner_filters[1]  = make_filter(100, 0, 1'b0, 1'b0, 1'b1, 1'b0);
    // equal bounds
    corner_filters[2]  = make_filter(-5, -5, 1'b1, 1'b1, 1'b1, 1'b0);
    // equal bounds, half open
    corner_filters[3]  = make_filter(-5, -5, 1'b1, 1'b1, 1'b0, 1'b0);
    // nils only
    corner_filters[4]  = make_filter(NIL_VALUE, 7, 1'b0, 1'b1, 1'b0, 1'b0);
    corner_filters[5]  = make_filter(NIL_VALUE, 7, 1'b0, 1'b0, 1'b1, 1'b0);
    // no lower limit
    corner_filters[6]  = make_filter(NIL_VALUE, 50, 1'b1, 1'b0, 1'b1, 1'b0);
    // no upper limit
    corner_filters[7]  = make_filter(-50, NIL_VALUE, 1'b1, 1'b1, 1'b0, 1'b0);
    corner_filters[8]  = make_filter(NIL_VALUE, NIL_VALUE, 1'b1, 1'b1, 1'b1, 1'b0);
    // anti, nil low
    corner_filters[9]  = make_filter(NIL_VALUE, 50, 1'b1, 1'b0, 1'b1, 1'b1);
    // anti, nil high
    corner_filters[10] = make_filter(-50, NIL_VALUE, 1'b1, 1'b1, 1'b0, 1'b1);
    corner_filters[11] = make_filter(NIL_VALUE, NIL_VALUE, 1'b1, 1'b0, 1'b0, 1'b1);
    // anti nil point
    corner_filters[12] = make_filter(NIL_VALUE, 3, 1'b0, 1'b1, 1'b1, 1'b1);
    corner_filters[13] = make_filter(-20, 20, 1'b1, 1'b0, 1'b1, 1'b1);
    // anti point
    corner_filters[14] = make_filter(3, 9, 1'b0, 1'b1, 1'b0, 1'b1);
    // inverted
    corner_filters[15] = make_filter(30, -30, 1'b1, 1'b1, 1'b1, 1'b0);
    corner_filters[16] = make_filter(30, -30, 1'b1, 1'b1, 1'b1, 1'b1);
    corner_filters[17] = make_filter(MAX_VALUE, MAX_VALUE, 1'b1, 1'b1, 1'b1, 1'b0);
    corner_filters[18] = make_filter(NIL_VALUE + 1, MAX_VALUE, 1'b1, 1'b1, 1'b1, 1'b0);
    corner_filters[19] = make_filter(NIL_VALUE + 1, MAX_VALUE, 1'b1, 1'b0, 1'b0, 1'b1);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Extremes of every field under the reset setting, then under the inclusive range from -1 to the largest value.
    for (int pass = 0; pass < 2; pass++) begin
      for (int k = 0; k < 8; k++) begin
        row.row_id = (k % 2) ? '1 : '0;
        row.last   = k[1];
        case (k)
          0: row.value = NIL_VALUE;
          1: row.value = NIL_VALUE + 1;
          2: row.value = '1;
          3: row.value = '0;
          4: row.value = 1;
          5: row.value = MAX_VALUE;
          6: row.value = MAX_VALUE - 1;
          default: row.value = $urandom;
        endcase
        pending_rows.push_back(row);
      end
      drain();
      if (pass == 0) apply_filter(make_filter(-1, MAX_VALUE, 1'b1, 1'b1, 1'b1, 1'b0));
    end

    for (int phase = 0; phase < PHASE_CNT; phase++) begin
      next_filter = (phase < CORNER_CNT) ? corner_filters[phase] : random_filter();
      if (phase < PHASE_CNT / 3) begin
        send_idle_pct = 35;
        recv_idle_pct = 61;
      end else if (phase < 2 * PHASE_CNT / 3) begin
        send_idle_pct = 61;
        recv_idle_pct = 35;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      apply_filter(next_filter);
      row_cnt = $urandom_range(54, 30);
      for (int k = 0; k < row_cnt; k++) pending_rows.push_back(random_row());
      drain();
    end

    repeat (10) @(posedge clk);
    if (expected_verdicts.size() != 0) mismatches += expected_verdicts.size();
    $display("Sent %0d rows under %0d filter settings; %0d verdicts back, %0d selected.",
             rows_sent, filter_settings, verdicts_seen, rows_selected);
    $display("Mismatches: %0d.", mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ column_range_select_filter.f @@
rtl/core/crsf_pkg.sv
rtl/core/crsf_decode.sv
rtl/core/column_range_select_filter.sv
tb/tb_top.sv
